@@ sv/mihp_pkg.sv @@
// ----------------------------------------------------------------------------
// mihp_pkg: map info header parser shared types and constants
// Phase codes, status codes, field widths and the result record.
// ----------------------------------------------------------------------------
package mihp_pkg;

  localparam int unsigned MAX_DIM   = 256;
  localparam int unsigned DIM_W     = $clog2(MAX_DIM + 1);
  localparam int unsigned FIELD_W   = 9;
  localparam int unsigned STATUS_W  = 3;
  localparam int unsigned WORD_W    = 32;
  localparam int unsigned BYTE_W    = 8;
  localparam int unsigned SEEN_W    = 5;
  localparam int unsigned MIN_LEN   = 24;
  localparam int unsigned VER_SKIP  = 24;
  localparam int unsigned CFG_ADDR_W = 3;
  localparam int unsigned CFG_DATA_W = 32;
  localparam logic [WORD_W-1:0] MAGIC_RESET = 32'h4D61_7049;

  localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
  localparam logic [STATUS_W-1:0] ST_TOO_SHORT = 3'd1;
  localparam logic [STATUS_W-1:0] ST_BAD_MAGIC = 3'd2;
  localparam logic [STATUS_W-1:0] ST_OVERSIZE  = 3'd3;
  localparam logic [STATUS_W-1:0] ST_BAD_RECT  = 3'd4;
  localparam logic [STATUS_W-1:0] ST_EARLY_END = 3'd5;

  localparam logic [0:0] REG_MAGIC = 1'b0;

  typedef enum logic [11:0] {
    PH_MAGIC   = 12'b0000_0000_0001,
    PH_VERSION = 12'b0000_0000_0010,
    PH_VSKIP   = 12'b0000_0000_0100,
    PH_WIDTH   = 12'b0000_0000_1000,
    PH_HEIGHT  = 12'b0000_0001_0000,
    PH_SKIP8   = 12'b0000_0010_0000,
    PH_ZEROS   = 12'b0000_0100_0000,
    PH_STR1    = 12'b0000_1000_0000,
    PH_STR2    = 12'b0001_0000_0000,
    PH_RECT    = 12'b0010_0000_0000,
    PH_DONE    = 12'b0100_0000_0000,
    PH_HALT    = 12'b1000_0000_0000
  } phase_t;

  typedef struct packed {
    logic [BYTE_W-1:0] data_byte;
    logic              last_byte;
  } in_item_t;

  typedef struct packed {
    logic [FIELD_W-1:0]  playable_height;
    logic [FIELD_W-1:0]  playable_width;
    logic [FIELD_W-1:0]  play_top;
    logic [FIELD_W-1:0]  play_right;
    logic [FIELD_W-1:0]  play_bottom;
    logic [FIELD_W-1:0]  play_left;
    logic [FIELD_W-1:0]  map_height;
    logic [FIELD_W-1:0]  map_width;
    logic [STATUS_W-1:0] status;
  } result_t;

  localparam int unsigned RESULT_W = $bits(result_t);
  localparam int unsigned OUT_DATA_W = ((RESULT_W + 7) / 8) * 8;

endpackage

@@ sv/mihp_cfg.sv @@
// ----------------------------------------------------------------------------
// mihp_cfg: configuration register file
// APB-style access to the magic word register.
// ----------------------------------------------------------------------------
module mihp_cfg (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_psel,
  input  logic                             cfg_penable,
  input  logic                             cfg_pwrite,
  input  logic [mihp_pkg::CFG_ADDR_W-1:0]  cfg_paddr,
  input  logic [mihp_pkg::CFG_DATA_W-1:0]  cfg_pwdata,
  output logic [mihp_pkg::CFG_DATA_W-1:0]  cfg_prdata,
  output logic                             cfg_pready,
  output logic [mihp_pkg::WORD_W-1:0]      magic_word
);
  import mihp_pkg::*;

  logic [WORD_W-1:0] magic_r;
  logic [0:0]        reg_idx;
  logic              wr_en;

  assign reg_idx    = cfg_paddr[CFG_ADDR_W-1:2];
  assign cfg_pready = 1'b1;
  assign wr_en      = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      magic_r <= MAGIC_RESET;
    end else if (wr_en && reg_idx == REG_MAGIC) begin
      magic_r <= cfg_pwdata[WORD_W-1:0];
    end
  end

  assign cfg_prdata = (reg_idx == REG_MAGIC) ? magic_r : '0;
  assign magic_word = magic_r;

endmodule

@@ sv/mihp_in_reg.sv @@
// ----------------------------------------------------------------------------
// mihp_in_reg: input register
// Holds one byte transaction until the parser consumes it.
// ----------------------------------------------------------------------------
module mihp_in_reg (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  mihp_pkg::in_item_t    in_item,
  input  logic                  out_free,
  output logic                  take,
  output mihp_pkg::in_item_t    item
);
  import mihp_pkg::*;

  logic     valid_r;
  in_item_t item_r;

  // a final byte waits for a free result slot
  assign take      = valid_r & (~item_r.last_byte | out_free);
  assign in_tready = ~valid_r | take;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_tready) begin
      valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      item_r <= in_item;
    end
  end

  assign item = item_r;

endmodule

@@ sv/mihp_parse.sv @@
// ----------------------------------------------------------------------------
// mihp_parse: header parse state
// Advances the parse phase by one byte and forms the result on the final byte.
// ----------------------------------------------------------------------------
module mihp_parse (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         take,
  input  mihp_pkg::in_item_t           item,
  input  logic [mihp_pkg::WORD_W-1:0]  magic_word,
  output logic                         res_load,
  output mihp_pkg::result_t            res
);
  import mihp_pkg::*;

  phase_t             phase_r, phase_nxt;
  logic [2:0]         biw_r, biw_nxt;
  logic [WORD_W-1:0]  wsh_r, wsh_nxt;
  logic [SEEN_W-1:0]  seen_r, seen_nxt;
  logic [DIM_W-1:0]   held_w_r, held_w_nxt;
  logic [DIM_W-1:0]   held_h_r, held_h_nxt;
  logic               w_big_r, w_big_nxt;
  logic [DIM_W-1:0]   rect_r   [4];
  logic [DIM_W-1:0]   rect_nxt [4];
  logic [3:0]         rbig_r, rbig_nxt;
  logic [1:0]         ridx_r, ridx_nxt;
  logic [STATUS_W-1:0] err_r, err_nxt;

  logic [WORD_W-1:0]  word;
  logic               word_big;
  logic [DIM_W-1:0]   word_dim;
  logic               h_big;
  logic               rect_bad;
  logic [STATUS_W-1:0] status;

  assign word     = {item.data_byte, wsh_r[WORD_W-1:BYTE_W]};
  assign word_big = word > WORD_W'(MAX_DIM);
  assign word_dim = word[DIM_W-1:0];
  assign h_big    = word_big;

  assign rect_bad = (|rbig_r[2:0]) | word_big |
                    (rect_r[0] > rect_r[2]) | (rect_r[2] > held_w_r) |
                    (rect_r[1] > word_dim)  | (word_dim > held_h_r);

  always_comb begin
    phase_nxt  = phase_r;
    biw_nxt    = biw_r;
    wsh_nxt    = wsh_r;
    seen_nxt   = seen_r;
    held_w_nxt = held_w_r;
    held_h_nxt = held_h_r;
    w_big_nxt  = w_big_r;
    rect_nxt   = rect_r;
    rbig_nxt   = rbig_r;
    ridx_nxt   = ridx_r;
    err_nxt    = err_r;
    if (take) begin
      if (seen_r < SEEN_W'(MIN_LEN)) begin
        seen_nxt = seen_r + 1'b1;
      end
      unique case (phase_r)
        PH_MAGIC, PH_VERSION, PH_WIDTH, PH_HEIGHT, PH_RECT: begin
          wsh_nxt = word;
          biw_nxt = biw_r + 1'b1;
          if (biw_r == 3'd3) begin
            biw_nxt = '0;
            unique case (phase_r)
              PH_MAGIC: begin
                if (word != magic_word) begin
                  err_nxt   = ST_BAD_MAGIC;
                  phase_nxt = PH_HALT;
                end else begin
                  phase_nxt = PH_VERSION;
                end
              end
              PH_VERSION: begin
                phase_nxt = (word == WORD_W'(VER_SKIP)) ? PH_VSKIP : PH_WIDTH;
              end
              PH_WIDTH: begin
                held_w_nxt = word_dim;
                w_big_nxt  = word_big;
                phase_nxt  = PH_HEIGHT;
              end
              PH_HEIGHT: begin
                held_h_nxt = word_dim;
                if (w_big_r || h_big) begin
                  err_nxt   = ST_OVERSIZE;
                  phase_nxt = PH_HALT;
                end else begin
                  phase_nxt = PH_SKIP8;
                end
              end
              default: begin
                rect_nxt[ridx_r] = word_dim;
                rbig_nxt[ridx_r] = word_big;
                if (ridx_r == 2'd3) begin
                  if (rect_bad) begin
                    err_nxt   = ST_BAD_RECT;
                    phase_nxt = PH_HALT;
                  end else begin
                    phase_nxt = PH_DONE;
                  end
                end else begin
                  ridx_nxt = ridx_r + 1'b1;
                end
              end
            endcase
          end
        end
        PH_VSKIP, PH_SKIP8: begin
          if (biw_r == 3'd7) begin
            biw_nxt   = '0;
            phase_nxt = (phase_r == PH_VSKIP) ? PH_WIDTH : PH_ZEROS;
          end else begin
            biw_nxt = biw_r + 1'b1;
          end
        end
        PH_ZEROS: begin
          if (item.data_byte != '0) begin
            phase_nxt = PH_STR1;
          end
        end
        PH_STR1: begin
          if (item.data_byte == '0) begin
            phase_nxt = PH_STR2;
          end
        end
        PH_STR2: begin
          if (item.data_byte == '0) begin
            phase_nxt = PH_RECT;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    priority if (seen_nxt < SEEN_W'(MIN_LEN)) begin
      status = ST_TOO_SHORT;
    end else if (err_nxt != ST_OK) begin
      status = err_nxt;
    end else if (phase_nxt != PH_DONE) begin
      status = ST_EARLY_END;
    end else begin
      status = ST_OK;
    end
  end

  always_comb begin
    res        = '0;
    res.status = status;
    if (status == ST_OK) begin
      res.map_width       = FIELD_W'(held_w_nxt);
      res.map_height      = FIELD_W'(held_h_nxt);
      res.play_left       = FIELD_W'(rect_nxt[0]);
      res.play_bottom     = FIELD_W'(rect_nxt[1]);
      res.play_right      = FIELD_W'(rect_nxt[2]);
      res.play_top        = FIELD_W'(rect_nxt[3]);
      res.playable_width  = FIELD_W'(rect_nxt[2] - rect_nxt[0]);
      res.playable_height = FIELD_W'(rect_nxt[3] - rect_nxt[1]);
    end
  end

  assign res_load = take & item.last_byte;

  // restart on the final byte
  always_ff @(posedge clk) begin
    if (!rst_n || res_load) begin
      phase_r  <= PH_MAGIC;
      biw_r    <= '0;
      wsh_r    <= '0;
      seen_r   <= '0;
      held_w_r <= '0;
      held_h_r <= '0;
      w_big_r  <= 1'b0;
      rbig_r   <= '0;
      ridx_r   <= '0;
      err_r    <= ST_OK;
      for (int i = 0; i < 4; i++) begin
        rect_r[i] <= '0;
      end
    end else begin
      phase_r  <= phase_nxt;
      biw_r    <= biw_nxt;
      wsh_r    <= wsh_nxt;
      seen_r   <= seen_nxt;
      held_w_r <= held_w_nxt;
      held_h_r <= held_h_nxt;
      w_big_r  <= w_big_nxt;
      rbig_r   <= rbig_nxt;
      ridx_r   <= ridx_nxt;
      err_r    <= err_nxt;
      for (int i = 0; i < 4; i++) begin
        rect_r[i] <= rect_nxt[i];
      end
    end
  end

endmodule

@@ sv/mihp_out_reg.sv @@
// ----------------------------------------------------------------------------
// mihp_out_reg: result register
// Holds one result transaction until the sink takes it.
// ----------------------------------------------------------------------------
module mihp_out_reg (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                res_load,
  input  mihp_pkg::result_t                   res,
  output logic                                out_free,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [mihp_pkg::OUT_DATA_W-1:0]     out_tdata
);
  import mihp_pkg::*;

  logic    valid_r;
  result_t res_r;

  assign out_free = ~valid_r | out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (res_load) begin
      valid_r <= 1'b1;
    end else if (out_tready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      res_r <= res;
    end
  end

  assign out_tvalid = valid_r;
  assign out_tdata  = OUT_DATA_W'(res_r);

endmodule

@@ sv/map_info_header_parser_top.sv @@
// ----------------------------------------------------------------------------
// map_info_header_parser_top: map info header parser
// Checks magic, reads version, map size and playable rectangle.
//
//   channel  direction  fields
//   in_      stream in  tdata[7:0] data_byte, tlast last_byte
//   out_     stream out tdata status, sizes, rectangle, playable size
//   cfg_     APB        magic_word at address 0
//
// One byte per clock; a byte passes the input and then the result register.
// The per-byte phase update in the parse stage sets that rate. A held result
// stalls only the final byte of the next file. Reset restores the magic word
// and the parse state; no clearing pass.
// ----------------------------------------------------------------------------
module map_info_header_parser_top (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [7:0]                          in_tdata,   // [7:0] data_byte
  input  logic                                in_tlast,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // [2:0] status, [11:3] map_width, [20:12] map_height, [29:21] play_left,
  // [38:30] play_bottom, [47:39] play_right, [56:48] play_top,
  // [65:57] playable_width, [74:66] playable_height, [79:75] zero
  output logic [mihp_pkg::OUT_DATA_W-1:0]     out_tdata,
  input  logic                                cfg_psel,
  input  logic                                cfg_penable,
  input  logic                                cfg_pwrite,
  input  logic [mihp_pkg::CFG_ADDR_W-1:0]     cfg_paddr,
  input  logic [mihp_pkg::CFG_DATA_W-1:0]     cfg_pwdata,
  output logic [mihp_pkg::CFG_DATA_W-1:0]     cfg_prdata,
  output logic                                cfg_pready
);
  import mihp_pkg::*;

  logic [WORD_W-1:0] magic_word;
  in_item_t          in_item;
  in_item_t          item;
  logic              take;
  logic              out_free;
  logic              res_load;
  result_t           res;

  assign in_item.data_byte = in_tdata;
  assign in_item.last_byte = in_tlast;

  mihp_cfg u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .magic_word  (magic_word)
  );

  mihp_in_reg u_in_reg (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_item   (in_item),
    .out_free  (out_free),
    .take      (take),
    .item      (item)
  );

  mihp_parse u_parse (
    .clk        (clk),
    .rst_n      (rst_n),
    .take       (take),
    .item       (item),
    .magic_word (magic_word),
    .res_load   (res_load),
    .res        (res)
  );

  mihp_out_reg u_out_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .res_load   (res_load),
    .res        (res),
    .out_free   (out_free),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

@@ bench/map_info_header_parser_top_tb.sv @@
// ----------------------------------------------------------------------------
// map_info_header_parser_top_tb: byte-stream test of the map info header parser
// Streams whole map info files through the input channel, one transaction per
// byte. Directed files hit each status code and the size and rectangle limits.
// Random files are mostly well formed with random content, plus truncated,
// corrupted and noise files. Each result is checked field by field against a
// parser model kept here. The magic word is written and read back between
// phases, and in the first two phases both sides stall at random.
// ----------------------------------------------------------------------------
module map_info_header_parser_top_tb;
  import mihp_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam logic [CFG_ADDR_W-1:0] MAGIC_ADDR = CFG_ADDR_W'(4 * REG_MAGIC);

  typedef struct {
    logic [7:0] data;
    logic       last;
    bit         drain;
  } wire_byte_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [7:0]            in_tdata = '0;
  logic                  in_tlast = 1'b0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  cfg_psel = 1'b0;
  logic                  cfg_penable = 1'b0;
  logic                  cfg_pwrite = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_paddr = '0;
  logic [CFG_DATA_W-1:0] cfg_pwdata = '0;
  logic [CFG_DATA_W-1:0] cfg_prdata;
  logic                  cfg_pready;

  wire_byte_t  byte_stream[$];
  logic [7:0]  file_buf[$];
  result_t     pending_headers[$];
  bit          in_took = 1'b0;
  int unsigned send_idle = 0;
  int unsigned recv_idle = 0;
  int unsigned errors = 0;
  int unsigned cycle_count = 0;

  logic [31:0] magic_cfg = MAGIC_RESET;
  phase_t      p_phase = PH_MAGIC;
  int unsigned p_count = 0;
  logic [31:0] p_shift = '0;
  int unsigned p_seen = 0;
  logic [31:0] p_width = '0;
  logic [31:0] p_height = '0;
  logic [31:0] p_rect[4] = '{default: '0};
  int unsigned p_ridx = 0;
  logic [STATUS_W-1:0] p_error = ST_OK;

  map_info_header_parser_top dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tlast    (in_tlast),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  task automatic report_mismatch(input string msg);
    errors++;
    if (errors <= 100) begin
      $display("mismatch at cycle %0d: %s", cycle_count, msg);
    end
  endtask

  function automatic bit parse_byte(input logic [7:0] b, input logic last,
                                    output result_t r);
    logic [STATUS_W-1:0] st;
    logic [31:0] span_x;
    logic [31:0] span_y;
    r = '0;
    if (p_seen < MIN_LEN) p_seen++;
    case (p_phase)
      PH_MAGIC, PH_VERSION, PH_WIDTH, PH_HEIGHT, PH_RECT: begin
        p_shift = {b, p_shift[31:8]};
        p_count++;
        if (p_count == 4) begin
          p_count = 0;
          case (p_phase)
            PH_MAGIC: begin
              if (p_shift != magic_cfg) begin
                p_error = ST_BAD_MAGIC;
                p_phase = PH_HALT;
              end else begin
                p_phase = PH_VERSION;
              end
            end
            PH_VERSION: p_phase = (p_shift == VER_SKIP) ? PH_VSKIP : PH_WIDTH;
            PH_WIDTH: begin
              p_width = p_shift;
              p_phase = PH_HEIGHT;
            end
            PH_HEIGHT: begin
              p_height = p_shift;
              if (p_width > MAX_DIM || p_height > MAX_DIM) begin
                p_error = ST_OVERSIZE;
                p_phase = PH_HALT;
              end else begin
                p_phase = PH_SKIP8;
              end
            end
            default: begin
              p_rect[p_ridx] = p_shift;
              if (p_ridx == 3) begin
                if (p_rect[0] > p_rect[2] || p_rect[2] > p_width ||
                    p_rect[1] > p_rect[3] || p_rect[3] > p_height) begin
                  p_error = ST_BAD_RECT;
                  p_phase = PH_HALT;
                end else begin
                  p_phase = PH_DONE;
                end
              end else begin
                p_ridx++;
              end
            end
          endcase
        end
      end
      PH_VSKIP, PH_SKIP8: begin
        if (p_count >= 7) begin
          p_count = 0;
          p_phase = (p_phase == PH_VSKIP) ? PH_WIDTH : PH_ZEROS;
        end else begin
          p_count++;
        end
      end
      PH_ZEROS: if (b != 8'h00) p_phase = PH_STR1;
      PH_STR1:  if (b == 8'h00) p_phase = PH_STR2;
      PH_STR2:  if (b == 8'h00) p_phase = PH_RECT;
      default: ;
    endcase
    if (!last) return 1'b0;

    if (p_seen < MIN_LEN) st = ST_TOO_SHORT;
    else if (p_error != ST_OK) st = p_error;
    else if (p_phase != PH_DONE) st = ST_EARLY_END;
    else st = ST_OK;
    r.status = st;
    if (st == ST_OK) begin
      span_x = p_rect[2] - p_rect[0];
      span_y = p_rect[3] - p_rect[1];
      r.map_width       = p_width[FIELD_W-1:0];
      r.map_height      = p_height[FIELD_W-1:0];
      r.play_left       = p_rect[0][FIELD_W-1:0];
      r.play_bottom     = p_rect[1][FIELD_W-1:0];
      r.play_right      = p_rect[2][FIELD_W-1:0];
      r.play_top        = p_rect[3][FIELD_W-1:0];
      r.playable_width  = span_x[FIELD_W-1:0];
      r.playable_height = span_y[FIELD_W-1:0];
    end
    p_phase = PH_MAGIC;
    p_count = 0;
    p_shift = '0;
    p_seen = 0;
    p_width = '0;
    p_height = '0;
    p_rect = '{default: '0};
    p_ridx = 0;
    p_error = ST_OK;
    return 1'b1;
  endfunction

  // drive: hold a presented byte until taken, stall on drain marks
  always @(negedge clk) begin
    out_tready <= ($urandom_range(99) >= recv_idle);
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!in_tvalid || in_took) begin
      if (byte_stream.size() != 0 &&
          !(byte_stream[0].drain && pending_headers.size() != 0) &&
          $urandom_range(99) >= send_idle) begin
        in_tvalid <= 1'b1;
        in_tdata  <= byte_stream[0].data;
        in_tlast  <= byte_stream[0].last;
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin : monitor
    result_t want_hdr;
    result_t got_hdr;
    in_took = rst_n && in_tvalid && in_tready;
    if (in_took) begin
      if (parse_byte(in_tdata, in_tlast, want_hdr)) pending_headers.push_back(want_hdr);
      void'(byte_stream.pop_front());
    end
    if (rst_n && out_tvalid && out_tready) begin
      got_hdr = out_tdata[RESULT_W-1:0];
      if (pending_headers.size() == 0) begin
        report_mismatch("result transaction with no file pending");
      end else begin
        want_hdr = pending_headers.pop_front();
        if (got_hdr.status != want_hdr.status)
          report_mismatch($sformatf("status %0d, want %0d",
                                    got_hdr.status, want_hdr.status));
        if (got_hdr.map_width != want_hdr.map_width)
          report_mismatch($sformatf("map_width %0d, want %0d",
                                    got_hdr.map_width, want_hdr.map_width));
        if (got_hdr.map_height != want_hdr.map_height)
          report_mismatch($sformatf("map_height %0d, want %0d",
                                    got_hdr.map_height, want_hdr.map_height));
        if (got_hdr.play_left != want_hdr.play_left)
          report_mismatch($sformatf("play_left %0d, want %0d",
                                    got_hdr.play_left, want_hdr.play_left));
        if (got_hdr.play_bottom != want_hdr.play_bottom)
          report_mismatch($sformatf("play_bottom %0d, want %0d",
                                    got_hdr.play_bottom, want_hdr.play_bottom));
        if (got_hdr.play_right != want_hdr.play_right)
          report_mismatch($sformatf("play_right %0d, want %0d",
                                    got_hdr.play_right, want_hdr.play_right));
        if (got_hdr.play_top != want_hdr.play_top)
          report_mismatch($sformatf("play_top %0d, want %0d",
                                    got_hdr.play_top, want_hdr.play_top));
        if (got_hdr.playable_width != want_hdr.playable_width)
          report_mismatch($sformatf("playable_width %0d, want %0d",
                                    got_hdr.playable_width, want_hdr.playable_width));
        if (got_hdr.playable_height != want_hdr.playable_height)
          report_mismatch($sformatf("playable_height %0d, want %0d",
                                    got_hdr.playable_height, want_hdr.playable_height));
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("map_info_header_parser_top_tb: done, errors");
      $finish;
    end
  end

  task automatic cfg_access(input bit wr, input logic [31:0] value);
    @(negedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= wr;
    cfg_paddr   <= MAGIC_ADDR;
    cfg_pwdata  <= value;
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    if (wr) magic_cfg = value;
    else if (cfg_prdata !== magic_cfg)
      report_mismatch($sformatf("magic_word read %h, want %h", cfg_prdata, magic_cfg));
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
  endtask

  task automatic set_magic(input logic [31:0] value);
    cfg_access(1'b1, value);
    cfg_access(1'b0, '0);
  endtask

  task automatic wait_drained();
    while (byte_stream.size() != 0 || pending_headers.size() != 0) @(negedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic put_word(input logic [31:0] w);
    file_buf.push_back(w[7:0]);
    file_buf.push_back(w[15:8]);
    file_buf.push_back(w[23:16]);
    file_buf.push_back(w[31:24]);
  endtask

  task automatic send_file(input bit drain);
    int i;
    for (i = 0; i < file_buf.size(); i++) begin
      byte_stream.push_back('{data: file_buf[i], last: (i == file_buf.size() - 1),
                              drain: (drain && i == 0)});
    end
    file_buf.delete();
  endtask

  task automatic build_map(input logic [31:0] ver, w, h, l, bo, r, t,
                           input int nz, s1, s2);
    put_word(magic_cfg);
    put_word(ver);
    if (ver == VER_SKIP) repeat (8) file_buf.push_back(8'($urandom));
    put_word(w);
    put_word(h);
    repeat (8) file_buf.push_back(8'($urandom));
    repeat (nz) file_buf.push_back(8'h00);
    repeat (s1) file_buf.push_back(8'($urandom_range(255, 1)));
    file_buf.push_back(8'h00);
    repeat (s2) file_buf.push_back(8'($urandom_range(255, 1)));
    file_buf.push_back(8'h00);
    put_word(l);
    put_word(bo);
    put_word(r);
    put_word(t);
  endtask

  function automatic logic [31:0] pick_dim();
    case ($urandom_range(3))
      0: return MAX_DIM;
      1: return $urandom_range(3);
      default: return $urandom_range(MAX_DIM);
    endcase
  endfunction

  task automatic directed_files();
    file_buf.push_back(8'hFF);
    send_file(1'b0);
    // short file wins over bad magic
    build_map(32'h0, 5, 5, 0, 0, 5, 5, 0, 1, 0);
    file_buf[0] = file_buf[0] ^ 8'h80;
    file_buf = file_buf[0:22];
    send_file(1'b0);
    build_map(VER_SKIP, MAX_DIM, MAX_DIM, 0, 0, MAX_DIM, MAX_DIM, 3, 5, 0);
    repeat (3) file_buf.push_back(8'($urandom));
    send_file(1'b0);
    build_map(32'h1800_0000, 0, 0, 0, 0, 0, 0, 0, 1, 6);
    send_file(1'b1);
    build_map(32'h0, 9, 9, 1, 1, 8, 8, 0, 1, 0);
    file_buf[3] = file_buf[3] ^ 8'h01;
    file_buf = file_buf[0:23];
    send_file(1'b0);
    build_map(32'h7, MAX_DIM + 1, 1, 0, 0, 1, 1, 0, 1, 0);
    send_file(1'b0);
    build_map(32'h7, 1, MAX_DIM + 1, 0, 0, 1, 1, 0, 1, 0);
    send_file(1'b0);
    build_map(VER_SKIP, 32'hFFFF_FFFF, 5, 0, 0, 1, 1, 1, 2, 2);
    send_file(1'b0);
    build_map(32'h0, 100, 50, 60, 0, 59, 50, 0, 1, 1);
    send_file(1'b0);
    build_map(32'h0, 100, 50, 0, 0, 101, 50, 0, 1, 1);
    send_file(1'b0);
    build_map(32'h0, 100, 50, 0, 30, 100, 29, 0, 1, 1);
    send_file(1'b0);
    build_map(32'h0, 100, 50, 0, 0, 100, 51, 0, 1, 1);
    send_file(1'b0);
    // data ending inside the rectangle, the skip field and the strings
    build_map(32'h0, 100, 50, 10, 20, 90, 40, 2, 3, 3);
    file_buf = file_buf[0:file_buf.size() - 6];
    send_file(1'b0);
    build_map(32'h0, 100, 50, 10, 20, 90, 40, 2, 3, 3);
    file_buf = file_buf[0:23];
    send_file(1'b0);
    build_map(32'h0, 100, 50, 10, 20, 90, 40, 2, 3, 3);
    file_buf = file_buf[0:27];
    send_file(1'b0);
  endtask

  task automatic random_file();
    logic [31:0] ver, w, h, l, bo, r, t;
    logic [31:0] big;
    int unsigned kind;
    int unsigned n;
    kind = $urandom_range(99);
    ver = ($urandom_range(1) != 0) ? 32'(VER_SKIP) : $urandom;
    w = pick_dim();
    h = pick_dim();
    l = $urandom_range(w);
    r = $urandom_range(w, l);
    bo = $urandom_range(h);
    t = $urandom_range(h, bo);
    if (kind >= 60 && kind < 70) begin
      case ($urandom_range(3))
        0: l = r + 1 + $urandom_range(300);
        1: r = w + 1 + $urandom_range(300);
        2: bo = t + 1 + $urandom_range(300);
        default: t = h + 1 + $urandom_range(300);
      endcase
    end else if (kind >= 70 && kind < 78) begin
      big = ($urandom_range(1) != 0) ? MAX_DIM + 1 + $urandom_range(20)
                                     : $urandom_range(32'hFFFF_FFFF, MAX_DIM + 1);
      if ($urandom_range(1) != 0) w = big;
      else h = big;
    end
    if (kind >= 92) begin
      n = $urandom_range(40, 1);
      repeat (n) file_buf.push_back(8'($urandom));
    end else begin
      build_map(ver, w, h, l, bo, r, t, $urandom_range(3), $urandom_range(6, 1),
                $urandom_range(6));
      if (kind >= 78 && kind < 86) begin
        n = $urandom_range(file_buf.size() - 1, 1);
        file_buf = file_buf[0:n-1];
      end else if (kind >= 86) begin
        n = $urandom_range(3);
        file_buf[n] = file_buf[n] ^ (8'h01 << $urandom_range(7));
      end else if (kind < 60 && $urandom_range(3) == 0) begin
        n = $urandom_range(6, 1);
        repeat (n) file_buf.push_back(8'($urandom));
      end
    end
    send_file($urandom_range(7) == 0);
  endtask

  task automatic run_random(input int unsigned byte_goal, input int unsigned file_goal);
    int unsigned bytes_sent;
    int unsigned files_sent;
    int unsigned depth;
    bytes_sent = 0;
    files_sent = 0;
    while (bytes_sent < byte_goal || files_sent < file_goal) begin
      depth = byte_stream.size();
      random_file();
      bytes_sent += byte_stream.size() - depth;
      files_sent++;
    end
    wait_drained();
  endtask

  initial begin
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    cfg_access(1'b0, '0);

    send_idle = 29;
    recv_idle = 71;
    directed_files();
    wait_drained();
    run_random(200, 4);

    send_idle = 71;
    recv_idle = 29;
    set_magic(32'hFFFF_FFFF);
    run_random(200, 4);

    send_idle = 0;
    recv_idle = 0;
    set_magic(32'h0000_0000);
    run_random(200, 4);

    set_magic($urandom);
    run_random(200, 4);

    repeat (8) @(posedge clk);
    if (errors == 0) begin
      $display("map_info_header_parser_top_tb: done, clean");
    end else begin
      $display("map_info_header_parser_top_tb: done, errors");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
sv/mihp_pkg.sv
sv/mihp_cfg.sv
sv/mihp_in_reg.sv
sv/mihp_parse.sv
sv/mihp_out_reg.sv
sv/map_info_header_parser_top.sv
bench/map_info_header_parser_top_tb.sv
